/* hw/rtl/lgs_pkg.sv */
// Shared types and constants for the Life generation stencil.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lgs_pkg;

    // Field and register widths.
    localparam int SIDE_W       = 6;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 4;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    // Default grid capacity and register reset value.
    localparam int MAX_SIDE_DEF = 32;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

    // Rule constants: birth on three, survival on two or three.
    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_LOW = 4'd2;

    // Which cell a result is taken from.
    typedef enum logic [1:0] {
        SRC_DIAG,
        SRC_EDGE,
        SRC_FLUSH
    } emit_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      emit;
        emit_src_t src;
        logic      advance;
        logic      flush_step;
        logic      clear;
    } lgs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_diag;
        logic has_edge;
        logic is_last;
        logic flush_done;
        logic slot_free;
    } lgs_status_t;

endpackage

`default_nettype wire

/* hw/rtl/life_generation_stencil.sv */
// Top level of the Life generation stencil; instantiates lgs_ctrl and lgs_datapath.
// Each cell takes three controller steps: IDLE loads it, DIAG releases the upper-left result and EDGE
// the row-end result; the last row of a frame then follows in FLUSH at one per cycle while the output
// is not stalled. A new cell is taken only after EDGE of the previous one, and a stalled output holds
// the controller in place.
// Reset clears the counters and row stores and sets grid_side to 32.
`default_nettype none

module life_generation_stencil #(
    parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration: grid_side.
    input  wire logic                              cfg_wr_en,
    input  wire logic [lgs_pkg::SIDE_W-1:0]        cfg_wr_data,
    // Input cells.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lgs_pkg::S_TDATA_W-1:0]     s_tdata,  // [0] cell_alive, [7:1] zero
    // Results.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] next_alive, [4:1] live_neighbours, [9:5] cell_row, [14:10] cell_col, [15] zero
    output logic [lgs_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tlast   // frame_last
);

    lgs_pkg::lgs_cmd_t    cmd;
    lgs_pkg::lgs_status_t status;

    logic                          next_alive;
    logic [lgs_pkg::CNT_W-1:0]     live_neighbours;
    logic [lgs_pkg::IDX_W-1:0]     cell_row;
    logic [lgs_pkg::IDX_W-1:0]     cell_col;

    lgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cell_alive      (s_tdata[0]),
        .cmd             (cmd),
        .status          (status),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .next_alive      (next_alive),
        .live_neighbours (live_neighbours),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .frame_last      (m_tlast)
    );

    // Pack the result fields, highest field first.
    assign m_tdata = {1'b0, cell_col, cell_row, live_neighbours, next_alive};

endmodule

`default_nettype wire

/* hw/rtl/lgs_ctrl.sv */
// Controller state machine of the Life generation stencil.
// Depends on lgs_pkg for the command and status structs.
`default_nettype none

module lgs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire lgs_pkg::lgs_status_t status,
    output lgs_pkg::lgs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIAG,
        ST_EDGE,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands for the current step.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.src        = lgs_pkg::SRC_DIAG;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIAG;
                end
            end
            ST_DIAG: begin
                // Release the upper-left neighbor of the new cell.
                cmd.src = lgs_pkg::SRC_DIAG;
                if (!status.has_diag) begin
                    state_next = ST_EDGE;
                end else if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE: begin
                // At the end of a row, release the last cell of the row above.
                cmd.src = lgs_pkg::SRC_EDGE;
                if (!status.has_edge || status.slot_free) begin
                    cmd.emit = status.has_edge;
                    if (status.is_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                // Walk the final row once the frame is complete.
                cmd.src = lgs_pkg::SRC_FLUSH;
                if (status.slot_free) begin
                    cmd.emit = 1'b1;
                    if (status.flush_done) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.flush_step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lgs_datapath.sv */
// Datapath of the Life generation stencil: row stores, counters, neighbor count
// and the output register. Depends on lgs_pkg.
`default_nettype none

module lgs_datapath #(
    parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lgs_pkg::SIDE_W-1:0]     cfg_wr_data,
    input  wire logic                           cell_alive,
    input  wire lgs_pkg::lgs_cmd_t              cmd,
    output lgs_pkg::lgs_status_t                status,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic                                next_alive,
    output logic [lgs_pkg::CNT_W-1:0]           live_neighbours,
    output logic [lgs_pkg::IDX_W-1:0]           cell_row,
    output logic [lgs_pkg::IDX_W-1:0]           cell_col,
    output logic                                frame_last
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int PW = $clog2(MAX_SIDE + 2);
    localparam int SW = lgs_pkg::SIDE_W;
    localparam int IW = lgs_pkg::IDX_W;
    localparam int NW = lgs_pkg::CNT_W;

    logic [SW-1:0]       side_reg;
    logic [MAX_SIDE-1:0] row0_reg, row1_reg, row2_reg;
    logic [MAX_SIDE-1:0] row0_next, row1_next, row2_next;
    logic [IW-1:0]       row_cnt_reg, col_cnt_reg, flush_col_reg;
    logic [IW-1:0]       row_cnt_next, col_cnt_next, flush_col_next;

    logic                m_valid_reg;
    logic                alive_reg, last_reg;
    logic [NW-1:0]       count_reg;
    logic [IW-1:0]       out_row_reg, out_col_reg;

    logic [SW-1:0]       side_eff;
    logic                row_end;

    // Side in use: zero acts as one, anything above capacity is clamped.
    always_comb begin
        if (side_reg == '0) begin
            side_eff = SW'(1);
        end else if (side_reg > SW'(MAX_SIDE)) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = side_reg;
        end
    end

    assign row_end = (({1'b0, col_cnt_reg} + SW'(1)) == side_eff);

    // Status toward the controller.
    always_comb begin
        status.has_diag   = (row_cnt_reg != '0) && (col_cnt_reg != '0);
        status.has_edge   = (row_cnt_reg != '0) && row_end;
        status.is_last    = row_end && (({1'b0, row_cnt_reg} + SW'(1)) == side_eff);
        status.flush_done = (({1'b0, flush_col_reg} + SW'(1)) == side_eff);
        status.slot_free  = !m_valid_reg || m_tready;
    end

    // Window selection for the cell being released.
    logic [MAX_SIDE-1:0] above, mid, below;
    logic [IW-1:0]       emit_row, emit_col;

    always_comb begin
        case (cmd.src)
            lgs_pkg::SRC_DIAG: begin
                above    = row0_reg;
                mid      = row1_reg;
                below    = row2_reg;
                emit_row = row_cnt_reg - IW'(1);
                emit_col = col_cnt_reg - IW'(1);
            end
            lgs_pkg::SRC_EDGE: begin
                above    = row0_reg;
                mid      = row1_reg;
                below    = row2_reg;
                emit_row = row_cnt_reg - IW'(1);
                emit_col = col_cnt_reg;
            end
            lgs_pkg::SRC_FLUSH: begin
                above    = row1_reg;
                mid      = row2_reg;
                below    = '0;
                emit_row = row_cnt_reg;
                emit_col = flush_col_reg;
            end
            default: begin
                above    = '0;
                mid      = '0;
                below    = '0;
                emit_row = '0;
                emit_col = '0;
            end
        endcase
    end

    // Neighbor count over zero-padded rows; the padding covers the left edge.
    logic [MAX_SIDE+1:0] pad_above, pad_mid, pad_below;
    logic [PW-1:0]       pidx;
    logic                right_ok;
    logic [NW-1:0]       nb_count;
    logic                self_alive;
    logic                rule_alive;
    logic                emit_last;

    always_comb begin
        pad_above  = {1'b0, above, 1'b0};
        pad_mid    = {1'b0, mid, 1'b0};
        pad_below  = {1'b0, below, 1'b0};
        pidx       = PW'(emit_col);
        right_ok   = (({1'b0, emit_col} + SW'(1)) < side_eff);
        self_alive = pad_mid[pidx + PW'(1)];
        nb_count   = NW'(pad_above[pidx]) + NW'(pad_mid[pidx]) + NW'(pad_below[pidx])
                   + NW'(pad_above[pidx + PW'(1)]) + NW'(pad_below[pidx + PW'(1)])
                   + NW'(pad_above[pidx + PW'(2)] & right_ok)
                   + NW'(pad_mid[pidx + PW'(2)] & right_ok)
                   + NW'(pad_below[pidx + PW'(2)] & right_ok);
        rule_alive = (nb_count == lgs_pkg::BIRTH_COUNT)
                   || (self_alive && (nb_count == lgs_pkg::SURVIVE_LOW));
        emit_last  = (({1'b0, emit_row} + SW'(1)) == side_eff)
                   && (({1'b0, emit_col} + SW'(1)) == side_eff);
    end

    // Row stores and position counters.
    always_comb begin
        row0_next      = row0_reg;
        row1_next      = row1_reg;
        row2_next      = row2_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        flush_col_next = flush_col_reg;
        if (cfg_wr_en || cmd.clear) begin
            row0_next      = '0;
            row1_next      = '0;
            row2_next      = '0;
            row_cnt_next   = '0;
            col_cnt_next   = '0;
            flush_col_next = '0;
        end else begin
            if (cmd.load) begin
                row2_next[col_cnt_reg[CW-1:0]] = row2_reg[col_cnt_reg[CW-1:0]] | cell_alive;
            end
            if (cmd.advance) begin
                if (row_end) begin
                    col_cnt_next = '0;
                    row_cnt_next = row_cnt_reg + IW'(1);
                    row0_next    = row1_reg;
                    row1_next    = row2_reg;
                    row2_next    = '0;
                end else begin
                    col_cnt_next = col_cnt_reg + IW'(1);
                end
            end
            if (cmd.flush_step) begin
                flush_col_next = flush_col_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg      <= lgs_pkg::SIDE_RESET;
            row0_reg      <= '0;
            row1_reg      <= '0;
            row2_reg      <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            flush_col_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                side_reg <= cfg_wr_data;
            end
            row0_reg      <= row0_next;
            row1_reg      <= row1_next;
            row2_reg      <= row2_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            flush_col_reg <= flush_col_next;
        end
    end

    // Output register: holds a result until the downstream transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            alive_reg   <= rule_alive;
            count_reg   <= nb_count;
            out_row_reg <= emit_row;
            out_col_reg <= emit_col;
            last_reg    <= emit_last;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign next_alive      = alive_reg;
    assign live_neighbours = count_reg;
    assign cell_row        = out_row_reg;
    assign cell_col        = out_col_reg;
    assign frame_last      = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/lgs_checker.sv */
// Port-level checks for the Life generation stencil, bound to the top level.
// Depends on lgs_pkg for the port widths.
`default_nettype none

module lgs_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lgs_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tlast
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A live result has two or three live neighbors.
    a_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[4:1] == 4'd2) || (m_tdata[4:1] == 4'd3))
        else $error("live result with wrong neighbor count");

    // The neighbor count never exceeds eight.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:1] <= 4'd8)
        else $error("neighbor count out of range");

    // The frame ends on the bottom-right corner, which lies on the diagonal.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[9:5] == m_tdata[14:10])
        else $error("frame end off the diagonal");

    // One cell is taken at a time.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
